FILE: hdl/ejs_pkg.sv
// Shared codes, types and constants for the encoder jog setpoint block.
package ejs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Input command codes
  localparam logic [1:0] CMD_UPDATE   = 2'd0;
  localparam logic [1:0] CMD_START    = 2'd1;
  localparam logic [1:0] CMD_STOP     = 2'd2;
  localparam logic [1:0] CMD_OVERRIDE = 2'd3;

  // Result action codes
  localparam logic [1:0] ACT_TRACK = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MED_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MED_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FACTOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING   = 3'd7;

  // Q8.8 unity
  localparam logic [15:0] UNITY_FACTOR = 16'd256;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_STOP,
    OP_OVERRIDE,
    OP_TIME,
    OP_TIER,
    OP_MUL1,
    OP_MUL2,
    OP_SUM,
    OP_SAT,
    OP_CLAMP,
    OP_EMIT,
    OP_EMIT_MOVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       active;
    logic       early;
    logic       read_ok;
    logic       delta_zero;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: hdl/ejs_ctrl.sv
// Sequencer for the encoder jog setpoint block.
module ejs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ejs_pkg::dp_stat_t stat,
  output ejs_pkg::ctl_cmd_t ctl
);
  import ejs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_TIER,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_SAT,
    S_CLAMP,
    S_EMIT,
    S_EMIT_MOVE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        unique case (stat.cmd)
          CMD_START: ctl.op = OP_START;
          CMD_STOP: begin
            if (stat.active) begin
              ctl.op    = OP_STOP;
              state_nxt = S_EMIT;
            end
          end
          CMD_OVERRIDE: begin
            ctl.op = OP_OVERRIDE;
            if (stat.active) state_nxt = S_EMIT;
          end
          CMD_UPDATE: begin
            if (stat.active && !stat.early) begin
              ctl.op = OP_TIME;
              if (stat.read_ok && !stat.delta_zero) state_nxt = S_TIER;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_TIER: begin
        ctl.op    = OP_TIER;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        ctl.op    = OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        ctl.op    = OP_MUL2;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctl.op    = OP_SUM;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        ctl.op    = OP_SAT;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        ctl.op    = OP_CLAMP;
        state_nxt = S_EMIT_MOVE;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctl.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_MOVE: begin
        if (stat.out_free) begin
          ctl.op    = OP_EMIT_MOVE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/ejs_dp.sv
// Datapath for the encoder jog setpoint block: config, state, multiplies, clamp, output register.
module ejs_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ejs_pkg::ctl_cmd_t                 ctl,
  output ejs_pkg::dp_stat_t                 stat,
  input  logic [1:0]                        in_cmd,
  input  logic signed [15:0]                in_encoder_count,
  input  logic                              in_read_ok,
  input  logic [31:0]                       in_now_ms,
  input  logic signed [31:0]                in_position,
  input  logic                              in_axis_referenced,
  input  logic signed [31:0]                in_limit_minus,
  input  logic signed [31:0]                in_limit_plus,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_action,
  output logic signed [31:0]                out_target,
  input  logic                              cfg_we,
  input  logic [ejs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ejs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ejs_pkg::*;

  // Configuration
  logic [15:0] interval_r;
  logic        invert_r;
  logic [14:0] med_cnt_r, high_cnt_r;
  logic [15:0] med_fac_r, high_fac_r, scale_r;
  logic        track_r;

  // Architectural state
  logic               active_r;
  logic signed [31:0] setpoint_r;
  logic [15:0]        prev_count_r;
  logic [31:0]        prev_ms_r;

  // Latched item
  logic [1:0]         cmd_r;
  logic [15:0]        cnt_r;
  logic               rok_r;
  logic [31:0]        now_r;
  logic signed [31:0] pos_r;
  logic               refd_r;
  logic signed [31:0] limm_r, limp_r;

  // Working registers
  logic [15:0]        cnt_eff_r;
  logic signed [15:0] delta_r;
  logic [15:0]        fac_r;
  logic signed [31:0] p1_r;
  logic [31:0]        pl_r;
  logic signed [32:0] ph_r;
  logic signed [49:0] sum_r;
  logic signed [31:0] next_r;
  logic signed [31:0] res_r;
  logic [1:0]         res_act_r;

  // Output register
  logic               out_valid_r;
  logic [1:0]         out_action_r;
  logic signed [31:0] out_target_r;

  // Decide-cycle logic
  logic [15:0] cnt_eff_w, delta_w;
  logic [31:0] elapsed_w;
  assign cnt_eff_w = invert_r ? 16'(16'd0 - cnt_r) : cnt_r;
  assign delta_w   = cnt_eff_w - prev_count_r;
  assign elapsed_w = now_r - prev_ms_r;

  // Tier selection
  logic [16:0] mag_w;
  logic [15:0] fac_w;
  assign mag_w = delta_r[15] ? 17'(17'd0 - {delta_r[15], delta_r}) : {1'b0, delta_r};
  always_comb begin
    priority if (mag_w >= {2'b00, high_cnt_r}) fac_w = high_fac_r;
    else if (mag_w >= {2'b00, med_cnt_r})      fac_w = med_fac_r;
    else                                       fac_w = UNITY_FACTOR;
  end

  // First multiply: delta * count_scale, fits 32 bits signed
  logic signed [16:0] d17, s17;
  logic signed [32:0] p1_w;
  assign d17  = {delta_r[15], delta_r};
  assign s17  = {1'b0, scale_r};
  assign p1_w = d17 * s17;

  // Second multiply split into 16-bit halves of p1
  logic [15:0]        p1_lo;
  logic signed [16:0] p1_hi, f17;
  logic [31:0]        pl_w;
  logic signed [32:0] ph_w;
  assign p1_lo = p1_r[15:0];
  assign p1_hi = {p1_r[31], p1_r[31:16]};
  assign f17   = {1'b0, fac_r};
  assign pl_w  = p1_lo * fac_r;
  assign ph_w  = p1_hi * f17;

  // Setpoint plus product
  logic signed [49:0] sum_w;
  assign sum_w = {ph_r[32], ph_r, 16'd0} + {18'd0, pl_r} + {{18{setpoint_r[31]}}, setpoint_r};

  // Saturation to 32 bits
  logic               fits_w;
  logic signed [31:0] sat_w;
  assign fits_w = (sum_r[49:31] == '0) || (sum_r[49:31] == '1);
  always_comb begin
    priority if (fits_w) sat_w = sum_r[31:0];
    else if (sum_r[49])  sat_w = 32'sh8000_0000;
    else                 sat_w = 32'sh7FFF_FFFF;
  end

  // Soft limit clamp
  logic signed [31:0] lo_w, clamp_w;
  assign lo_w    = (next_r < limm_r) ? limm_r : next_r;
  assign clamp_w = (lo_w > limp_r) ? limp_r : lo_w;

  assign stat.cmd        = cmd_r;
  assign stat.active     = active_r;
  assign stat.early      = elapsed_w < {16'd0, interval_r};
  assign stat.read_ok    = rok_r;
  assign stat.delta_zero = (delta_w == 16'd0);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_target = out_target_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 16'd10;
      invert_r   <= 1'b0;
      med_cnt_r  <= 15'h7FFF;
      high_cnt_r <= 15'h7FFF;
      med_fac_r  <= UNITY_FACTOR;
      high_fac_r <= UNITY_FACTOR;
      scale_r    <= UNITY_FACTOR;
      track_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL:    interval_r <= cfg_data;
        REG_INVERT:      invert_r   <= cfg_data[0];
        REG_MED_COUNT:   med_cnt_r  <= cfg_data[14:0];
        REG_HIGH_COUNT:  high_cnt_r <= cfg_data[14:0];
        REG_MED_FACTOR:  med_fac_r  <= cfg_data;
        REG_HIGH_FACTOR: high_fac_r <= cfg_data;
        REG_SCALE:       scale_r    <= cfg_data;
        REG_TRACKING:    track_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Architectural state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      setpoint_r   <= '0;
      prev_count_r <= '0;
      prev_ms_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // a new result may replace one taken at the same edge
      if (ctl.op == OP_EMIT || ctl.op == OP_EMIT_MOVE) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl.op)
        OP_START: begin
          active_r     <= 1'b1;
          setpoint_r   <= pos_r;
          prev_count_r <= '0;
          prev_ms_r    <= now_r;
        end
        OP_STOP:     active_r   <= 1'b0;
        OP_OVERRIDE: setpoint_r <= pos_r;
        OP_TIME:     prev_ms_r  <= now_r;
        OP_EMIT_MOVE: begin
          setpoint_r   <= res_r;
          prev_count_r <= cnt_eff_r;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        cmd_r  <= in_cmd;
        cnt_r  <= in_encoder_count;
        rok_r  <= in_read_ok;
        now_r  <= in_now_ms;
        pos_r  <= in_position;
        refd_r <= in_axis_referenced;
        limm_r <= in_limit_minus;
        limp_r <= in_limit_plus;
      end
      OP_STOP: begin
        res_act_r <= ACT_STOP;
        res_r     <= '0;
      end
      OP_OVERRIDE: begin
        res_act_r <= ACT_TRACK;
        res_r     <= pos_r;
      end
      OP_TIME: begin
        cnt_eff_r <= cnt_eff_w;
        delta_r   <= delta_w;
      end
      OP_TIER: fac_r  <= fac_w;
      OP_MUL1: p1_r   <= p1_w[31:0];
      OP_MUL2: begin
        pl_r <= pl_w;
        ph_r <= ph_w;
      end
      OP_SUM:  sum_r  <= sum_w;
      OP_SAT:  next_r <= sat_w;
      OP_CLAMP: begin
        res_act_r <= track_r ? ACT_TRACK : ACT_RUN;
        res_r     <= refd_r ? clamp_w : next_r;
      end
      OP_EMIT, OP_EMIT_MOVE: begin
        out_action_r <= res_act_r;
        out_target_r <= res_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/encoder_jog_setpoint.sv
// Top level of the encoder jog setpoint block.
//
//  Channel   Ports                              Direction  Handshake
//  in        in_valid/in_ready, in_* fields     into block valid/ready
//  out       out_valid/out_ready, out_action,   from block valid/ready
//            out_target
//  cfg       cfg_we, cfg_index, cfg_data        into block write strobe
//
// Sequence: start, ignored commands and early or failed updates go through
// accept and decide only. Stop and override while active go on through emit
// into the output register. A move runs accept, decide, tier select, two multiply
// steps (the second split into 16-bit halves), add, saturate, clamp, emit.
// Reset: rst_n synchronous, active low; config returns to its defaults,
// the axis goes inactive with setpoint, previous count and time cleared.
// Stalls: one result item is held in the output register; a new item is
// taken while it waits, and the sequencer parks at emit only if a second
// result is ready before the first has been taken.
module encoder_jog_setpoint (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic signed [15:0]                in_encoder_count,
  input  logic                              in_read_ok,
  input  logic [31:0]                       in_now_ms,
  input  logic signed [31:0]                in_position,
  input  logic                              in_axis_referenced,
  input  logic signed [31:0]                in_limit_minus,
  input  logic signed [31:0]                in_limit_plus,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_action,
  output logic signed [31:0]                out_target,
  input  logic                              cfg_we,
  input  logic [ejs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ejs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ejs_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // Sequencer: one datapath operation per cycle
  ejs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath: config, jog state, Q16.16 arithmetic, result register
  ejs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .in_cmd             (in_cmd),
    .in_encoder_count   (in_encoder_count),
    .in_read_ok         (in_read_ok),
    .in_now_ms          (in_now_ms),
    .in_position        (in_position),
    .in_axis_referenced (in_axis_referenced),
    .in_limit_minus     (in_limit_minus),
    .in_limit_plus      (in_limit_plus),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_target         (out_target),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

endmodule
